// ===== src/rwng_pkg.sv =====
// -----------------------------------------------------------------------------
// rwng_pkg
// Shared types and constants of the random walk noise generator.
// -----------------------------------------------------------------------------
package rwng_pkg;

    localparam int STEP_IN_W = 19;
    localparam int STEP_W    = 17;
    localparam int SAMPLE_W  = 26;
    localparam int GEN_W     = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    localparam int PROD_W    = 48;

    // Generator recurrence: g = g * LCG_MUL + LCG_ADD (mod 2^32)
    localparam logic [25:0]       LCG_MUL = 26'd40359821;
    localparam logic [GEN_W-1:0]  LCG_ADD = 32'd1;

    localparam logic [STEP_W-1:0] ONE_Q16 = 17'd65536;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_INPUT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED       = 8'd3;

    // Reset values
    localparam logic [STEP_W-1:0] RST_STEP_SIZE = 17'd655;
    localparam logic [GEN_W-1:0]  RST_SEED      = 32'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the step of the accepted beat
        logic lcg;       // advance the generator
        logic scale;     // multiply centred generator value by the step
        logic update;    // move the position and load the output
        logic zero;      // load a zero output, hold all state
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic run;       // walk is enabled
        logic out_free;  // output register can take a beat this cycle
    } t_dp_status;

endpackage

// ===== src/rwng_ctrl.sv =====
// -----------------------------------------------------------------------------
// rwng_ctrl
// Sequencer: accept a beat, then step the datapath through generator advance,
// scaling and position update, or load a zero output while the walk is stopped.
// -----------------------------------------------------------------------------
module rwng_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rwng_pkg::t_dp_status i_status,
    output rwng_pkg::t_dp_cmd    o_cmd
);
    import rwng_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LCG    = 5'b00010,
        ST_SCALE  = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_ZERO   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = i_status.run ? ST_LCG : ST_ZERO;
                end
            end
            ST_LCG: begin
                o_cmd.lcg = 1'b1;
                n_state   = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_UPDATE;
            end
            ST_UPDATE: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_ZERO: begin
                if (i_status.out_free) begin
                    o_cmd.zero = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == ST_IDLE);

endmodule

// ===== src/rwng_dp.sv =====
// -----------------------------------------------------------------------------
// rwng_dp
// Datapath: configuration registers, generator, shared multiplier, walk
// position and output register.
// -----------------------------------------------------------------------------
module rwng_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    input  logic [rwng_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [rwng_pkg::CFG_DAT_W-1:0]         i_cfg_data,
    input  logic signed [rwng_pkg::STEP_IN_W-1:0]  i_step_in,
    input  logic                                   i_ready,
    output logic                                   o_valid,
    output logic signed [rwng_pkg::SAMPLE_W-1:0]   o_sample,
    input  rwng_pkg::t_dp_cmd                      i_cmd,
    output rwng_pkg::t_dp_status                   o_status
);
    import rwng_pkg::*;

    logic [STEP_W-1:0]          r_step_size;
    logic                       r_use_input;
    logic                       r_run;
    logic [GEN_W-1:0]           r_gen;
    logic [STEP_W-1:0]          r_step;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SAMPLE_W-1:0] r_pos;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_out_valid;

    logic [STEP_W-1:0]          step_cfg;
    logic [STEP_W-1:0]          step_inp;
    logic signed [GEN_W-1:0]    centred;
    logic signed [32:0]         mul_a;
    logic signed [26:0]         mul_b;
    logic signed [59:0]         mul_p;
    logic signed [24:0]         inc;
    logic signed [26:0]         inc_ext;
    logic signed [26:0]         pos_ext;
    logic signed [26:0]         sum;
    logic signed [26:0]         refl;
    logic                       outside;
    logic signed [SAMPLE_W-1:0] n_pos;

    // clamp both step sources to 0..1.0
    assign step_cfg = (r_step_size > ONE_Q16) ? ONE_Q16 : r_step_size;

    always_comb begin
        if (i_step_in[STEP_IN_W-1]) begin
            step_inp = '0;
        end else if (i_step_in[STEP_IN_W-2:0] > {1'b0, ONE_Q16}) begin
            step_inp = ONE_Q16;
        end else begin
            step_inp = i_step_in[STEP_W-1:0];
        end
    end

    // one multiplier, shared by the generator advance and the step scaling
    assign centred = {~r_gen[GEN_W-1], r_gen[GEN_W-2:0]};
    assign mul_a   = i_cmd.scale ? {centred[GEN_W-1], centred} : {1'b0, r_gen};
    assign mul_b   = i_cmd.scale ? {10'd0, r_step} : {1'b0, LCG_MUL};
    assign mul_p   = mul_a * mul_b;

    // floor shift of the Q0.47 product to a Q0.24 increment
    assign inc     = r_prod[PROD_W-1:23];
    assign inc_ext = {{2{inc[24]}}, inc};
    assign pos_ext = {r_pos[SAMPLE_W-1], r_pos};
    assign sum     = pos_ext + inc_ext;
    assign refl    = pos_ext - inc_ext;
    assign outside = (sum > 27'sd16777216) || (sum < -27'sd16777216);
    assign n_pos   = outside ? refl[SAMPLE_W-1:0] : sum[SAMPLE_W-1:0];

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size <= RST_STEP_SIZE;
            r_use_input <= 1'b0;
            r_run       <= 1'b1;
            r_gen       <= RST_SEED;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_STEP_SIZE:  r_step_size <= i_cfg_data[STEP_W-1:0];
                    REG_USE_INPUT:  r_use_input <= i_cfg_data[0];
                    REG_RUN_ENABLE: r_run       <= i_cfg_data[0];
                    REG_SEED:       r_gen       <= i_cfg_data[GEN_W-1:0];
                    default: ;
                endcase
            end else if (i_cmd.lcg) begin
                r_gen <= mul_p[GEN_W-1:0] + LCG_ADD;
            end
            if (i_cmd.update) begin
                r_pos <= n_pos;
            end
            if (i_cmd.update || i_cmd.zero) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_step <= r_use_input ? step_inp : step_cfg;
        end
        if (i_cmd.scale) begin
            r_prod <= mul_p[PROD_W-1:0];
        end
        if (i_cmd.update) begin
            r_sample <= n_pos;
        end else if (i_cmd.zero) begin
            r_sample <= '0;
        end
    end

    assign o_status.run      = r_run;
    assign o_status.out_free = !r_out_valid || i_ready;
    assign o_valid           = r_out_valid;
    assign o_sample          = r_sample;

endmodule

// ===== src/random_walk_noise_generator.sv =====
// -----------------------------------------------------------------------------
// random_walk_noise_generator
// Brownian noise source: a 32-bit LCG drives a bounded random walk in Q1.24.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready): one beat per sample tick, carrying
//   i_step_in, a signed Q2.16 step used when use_input_step is set.
//   Output channel (o_valid / i_ready): one beat per input beat, o_sample is
//   the walk position in Q1.24, or zero while run_enable is clear.
//   Config channel (i_cfg_valid / o_cfg_ready): always ready; index 0 step
//   size, 1 use input step, 2 run enable, 3 seed (reloads the generator).
//   Other indexes are dropped. Write only while the block is idle.
// Sequence:
//   A running beat passes through accept, generator advance, step scaling and
//   position update. The two multiply steps share one 33x27 multiplier. A new
//   beat is accepted only in idle, once the last one is through. While stopped,
//   an accepted beat goes to a zero state that loads a zero sample.
// Reset and stall:
//   Reset restores the register defaults, seeds the generator with 1 and
//   centers the walk at zero. A stalled receiver holds the output register;
//   the next beat is still accepted and worked up to the update, which waits.
// -----------------------------------------------------------------------------
module random_walk_noise_generator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [rwng_pkg::STEP_IN_W-1:0]  i_step_in,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [rwng_pkg::SAMPLE_W-1:0]   o_sample,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [rwng_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [rwng_pkg::CFG_DAT_W-1:0]         i_cfg_data
);
    import rwng_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // configuration writes never stall
    assign o_cfg_ready = 1'b1;

    // sequencer: accepts a beat in idle, then drives the datapath steps
    rwng_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath: registers, generator, shared multiplier, walk and output
    rwng_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step_in   (i_step_in),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_sample    (o_sample),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

// ===== src/rwng_checker.sv =====
// -----------------------------------------------------------------------------
// rwng_checker
// Port-level checks of the random walk noise generator.
// -----------------------------------------------------------------------------
module rwng_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic                                   o_ready,
    input  logic                                   o_valid,
    input  logic                                   i_ready,
    input  logic signed [rwng_pkg::SAMPLE_W-1:0]   o_sample
);
    import rwng_pkg::*;

    // a stalled output beat stays and keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_sample)))
        else $error("output beat dropped or changed under stall");

    // the walk never leaves [-1, +1]
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_sample <= 26'sd16777216) && (o_sample >= -26'sd16777216)))
        else $error("sample outside the walk bounds");

    // one beat at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted while a beat is in flight");

    // no result can appear the cycle right after an accept from idle
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !o_valid) |=> !o_valid)
        else $error("result appeared without processing");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind random_walk_noise_generator rwng_checker u_rwng_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_sample (o_sample)
);
